### hw/rtl/script_tokenizer_top_defines.svh
// assertion macros for the script tokenizer
`ifndef SCRIPT_TOKENIZER_TOP_DEFINES_SVH
`define SCRIPT_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define STOK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define STOK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/stok_pkg.sv
// types, character codes and helpers shared by the script tokenizer
package stok_pkg;

   localparam logic [2:0] MODE_SKIP    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_QUOTE   = 3'd3;
   localparam logic [2:0] MODE_WORD    = 3'd4;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] held_byte;
      logic       held_valid;
   } state_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       has_byte;
      logic       token_end;
      logic       end_of_data;
      logic       run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_type;

   function automatic logic is_single(input logic [7:0] b);
      return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_RPAREN) ||
             (b == CH_LPAREN) || (b == CH_SQUOTE) || (b == CH_COMMA);
   endfunction

   function automatic result_type mk_result(input logic [7:0] b, input logic has,
                                            input logic tend, input logic eod);
      result_type r;
      r.token_byte  = has ? b : 8'h00;
      r.has_byte    = has;
      r.token_end   = tend;
      r.end_of_data = eod;
      r.run_last    = 1'b0;
      return r;
   endfunction

endpackage

### hw/rtl/stok_req_if.sv
// text byte channel
interface stok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

### hw/rtl/stok_rsp_if.sv
// token result channel
interface stok_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_byte;
   logic       has_byte;
   logic       token_end;
   logic       end_of_data;
   logic       run_last;

   modport source (output valid, output token_byte, output has_byte, output token_end,
                   output end_of_data, output run_last, input ready);
   modport sink (input valid, input token_byte, input has_byte, input token_end,
                 input end_of_data, input run_last, output ready);
endinterface

### hw/rtl/script_tokenizer_top.sv
// script tokenizer top level: parse state, step logic and result buffer
//
// usage
//   req_chan carries one script byte per transfer (text_byte, 0 = end of data).
//   rsp_chan carries token bytes with has_byte, token_end, end_of_data and
//   run_last; run_last marks the final result caused by one input byte.
//   each input byte gives zero, one or two results; one byte of a token is
//   held back so its last byte can carry token_end.
// timing: a result is presented in the cycle after the byte that causes it.
// throughput: one byte per cycle while rsp ready is high and each byte gives at
//   most one result; a byte that closes a word with a one-byte token gives two
//   results and fills the two-entry result buffer, so the next byte waits until
//   the first of them has been taken.
// reset: synchronous, active high; parse mode returns to skipping blanks,
//   the held byte and the result buffer are emptied.
// stall: when the receiver holds rsp ready low the buffer keeps its results
//   and req ready drops once the buffer cannot take a worst-case byte.
`include "script_tokenizer_top_defines.svh"

module script_tokenizer_top (
   input logic        clock,
   input logic        reset,
   stok_req_if.sink   req_chan,
   stok_rsp_if.source rsp_chan
);

   // parse state
   stok_pkg::state_type  state_ff;
   stok_pkg::state_type  state_in;
   stok_pkg::step_type   step;

   // two-entry result buffer, slot0 is the head
   stok_pkg::result_type slot0_ff, slot0_in;
   stok_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;

   logic req_xfer;
   logic rsp_xfer;

   stok_step u_step (
      .state_cur (state_ff),
      .text_byte (req_chan.text_byte),
      .state_nxt (state_in),
      .step      (step)
   );

   // accept only when the buffer is empty after this cycle's pop,
   // so both result slots are free for the new byte
   assign req_chan.ready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_chan.ready);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (req_xfer) begin
         // buffer drains empty this cycle, load the new results
         slot0_in = step.r0;
         slot1_in = step.r1;
         count_in = step.count;
      end else if (rsp_xfer) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= 2'd0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
      end
   end

   // payload slots need no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.token_byte  = slot0_ff.token_byte;
   assign rsp_chan.has_byte    = slot0_ff.has_byte;
   assign rsp_chan.token_end   = slot0_ff.token_end;
   assign rsp_chan.end_of_data = slot0_ff.end_of_data;
   assign rsp_chan.run_last    = slot0_ff.run_last;

   // a new byte never lands on top of undelivered results
   `STOK_ASSERT_NOW(a_no_overrun, req_xfer, count_ff == 2'd0 || (count_ff == 2'd1 && rsp_xfer),
      "byte accepted while results still pending")

   // a head result without run_last always has its partner queued behind it
   `STOK_ASSERT_NOW(a_pair_queued, rsp_chan.valid && !rsp_chan.run_last, count_ff == 2'd2,
      "first of a result pair without its partner")

   // end of data always brings the parser back to skipping with nothing held
   `STOK_ASSERT_NEXT(a_eod_resets, req_xfer && req_chan.text_byte == stok_pkg::CH_NUL,
      state_ff.mode == stok_pkg::MODE_SKIP && !state_ff.held_valid,
      "parser not idle after end of data")

endmodule

### hw/rtl/stok_step.sv
// per-byte parse step: next state and up to two results
module stok_step (
   input  stok_pkg::state_type state_cur,
   input  logic [7:0]          text_byte,
   output stok_pkg::state_type state_nxt,
   output stok_pkg::step_type  step
);

   logic [2:0] mode_eff;
   logic       is_eod;
   logic       is_blank;

   always_comb begin
      state_nxt = state_cur;
      step      = '0;
      is_eod    = (text_byte == stok_pkg::CH_NUL);
      is_blank  = (text_byte <= stok_pkg::CH_SPACE);
      mode_eff  = (state_cur.mode == stok_pkg::MODE_SLASH) ? stok_pkg::MODE_WORD
                                                           : state_cur.mode;

      if (state_cur.mode == stok_pkg::MODE_SLASH && text_byte == stok_pkg::CH_SLASH) begin
         // second slash: comment starts, held slash is dropped
         state_nxt.mode       = stok_pkg::MODE_COMMENT;
         state_nxt.held_byte  = 8'h00;
         state_nxt.held_valid = 1'b0;
      end else begin
         case (mode_eff)
            stok_pkg::MODE_COMMENT: begin
               if (is_eod) begin
                  step.count     = 2'd1;
                  step.r0        = stok_pkg::mk_result(8'h00, 1'b0, 1'b0, 1'b1);
                  state_nxt.mode = stok_pkg::MODE_SKIP;
               end else if (text_byte == stok_pkg::CH_LF) begin
                  state_nxt.mode = stok_pkg::MODE_SKIP;
               end
            end
            stok_pkg::MODE_QUOTE: begin
               if (is_eod || text_byte == stok_pkg::CH_DQUOTE) begin
                  step.count           = 2'd1;
                  step.r0              = stok_pkg::mk_result(state_cur.held_byte,
                                            state_cur.held_valid, 1'b1, is_eod);
                  state_nxt.mode       = stok_pkg::MODE_SKIP;
                  state_nxt.held_byte  = 8'h00;
                  state_nxt.held_valid = 1'b0;
               end else begin
                  if (state_cur.held_valid) begin
                     step.count = 2'd1;
                     step.r0    = stok_pkg::mk_result(state_cur.held_byte, 1'b1, 1'b0, 1'b0);
                  end
                  state_nxt.held_byte  = text_byte;
                  state_nxt.held_valid = 1'b1;
               end
            end
            stok_pkg::MODE_WORD: begin
               state_nxt.mode = stok_pkg::MODE_WORD;
               if (is_blank) begin
                  step.count           = 2'd1;
                  step.r0              = stok_pkg::mk_result(state_cur.held_byte,
                                            state_cur.held_valid, 1'b1, is_eod);
                  state_nxt.mode       = stok_pkg::MODE_SKIP;
                  state_nxt.held_byte  = 8'h00;
                  state_nxt.held_valid = 1'b0;
               end else if (stok_pkg::is_single(text_byte)) begin
                  step.count           = 2'd2;
                  step.r0              = stok_pkg::mk_result(state_cur.held_byte,
                                            state_cur.held_valid, 1'b1, 1'b0);
                  step.r1              = stok_pkg::mk_result(text_byte, 1'b1, 1'b1, 1'b0);
                  state_nxt.mode       = stok_pkg::MODE_SKIP;
                  state_nxt.held_byte  = 8'h00;
                  state_nxt.held_valid = 1'b0;
               end else begin
                  if (state_cur.held_valid) begin
                     step.count = 2'd1;
                     step.r0    = stok_pkg::mk_result(state_cur.held_byte, 1'b1, 1'b0, 1'b0);
                  end
                  state_nxt.held_byte  = text_byte;
                  state_nxt.held_valid = 1'b1;
               end
            end
            default: begin
               // skip mode, also any unused code
               state_nxt.mode       = stok_pkg::MODE_SKIP;
               state_nxt.held_byte  = 8'h00;
               state_nxt.held_valid = 1'b0;
               if (is_eod) begin
                  step.count = 2'd1;
                  step.r0    = stok_pkg::mk_result(8'h00, 1'b0, 1'b0, 1'b1);
               end else if (is_blank) begin
                  state_nxt.mode = stok_pkg::MODE_SKIP;
               end else if (text_byte == stok_pkg::CH_SLASH) begin
                  state_nxt.held_byte  = text_byte;
                  state_nxt.held_valid = 1'b1;
                  state_nxt.mode       = stok_pkg::MODE_SLASH;
               end else if (text_byte == stok_pkg::CH_DQUOTE) begin
                  state_nxt.mode = stok_pkg::MODE_QUOTE;
               end else if (stok_pkg::is_single(text_byte)) begin
                  step.count = 2'd1;
                  step.r0    = stok_pkg::mk_result(text_byte, 1'b1, 1'b1, 1'b0);
               end else begin
                  state_nxt.held_byte  = text_byte;
                  state_nxt.held_valid = 1'b1;
                  state_nxt.mode       = stok_pkg::MODE_WORD;
               end
            end
         endcase
      end

      // last result of this byte carries run_last
      if (step.count == 2'd1) begin
         step.r0.run_last = 1'b1;
      end else if (step.count == 2'd2) begin
         step.r1.run_last = 1'b1;
      end
   end

endmodule
